// ===== rtl/core/rmct_pkg.sv =====
package rmct_pkg;

    localparam int DEF_LEAF_COUNT = 1024;
    localparam int DEF_VALUE_BITS = 32;

    localparam int POS_BITS       = 10;
    localparam int RANGE_BITS     = 11;
    localparam int LEN_BITS       = 11;
    localparam int COUNT_OUT_BITS = 11;

    localparam logic [LEN_BITS-1:0] LEN_RESET = 11'd1024;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_QUERY
    } t_state;

    typedef struct packed {
        logic clearing;
        logic querying;
    } t_status;

endpackage

// ===== rtl/core/rmct_req_if.sv =====
interface rmct_req_if #(
    parameter int VALUE_BITS = rmct_pkg::DEF_VALUE_BITS
);
    logic                                valid;
    logic                                ready;
    logic                                opcode;
    logic [rmct_pkg::POS_BITS-1:0]       position;
    logic signed [VALUE_BITS-1:0]        wr_value;
    logic [rmct_pkg::RANGE_BITS-1:0]     range_start;
    logic [rmct_pkg::RANGE_BITS-1:0]     range_end;

    modport source (
        output valid, opcode, position, wr_value, range_start, range_end,
        input  ready
    );
    modport sink (
        input  valid, opcode, position, wr_value, range_start, range_end,
        output ready
    );
endinterface

// ===== rtl/core/rmct_rsp_if.sv =====
interface rmct_rsp_if #(
    parameter int VALUE_BITS = rmct_pkg::DEF_VALUE_BITS
);
    logic                                valid;
    logic                                ready;
    logic signed [VALUE_BITS-1:0]        min_value;
    logic [rmct_pkg::COUNT_OUT_BITS-1:0] min_count;
    logic                                range_empty;

    modport source (
        output valid, min_value, min_count, range_empty,
        input  ready
    );
    modport sink (
        input  valid, min_value, min_count, range_empty,
        output ready
    );
endinterface

// ===== rtl/core/rmct_ram.sv =====
module rmct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;
endmodule

// ===== rtl/core/rmct_ctrl.sv =====
module rmct_ctrl #(
    parameter int LEAF_COUNT = rmct_pkg::DEF_LEAF_COUNT,
    parameter int VALUE_BITS = rmct_pkg::DEF_VALUE_BITS,
    parameter int AW         = $clog2(LEAF_COUNT) + 1,
    parameter int EW         = VALUE_BITS + $clog2(LEAF_COUNT + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [rmct_pkg::LEN_BITS-1:0] i_active_length,
    rmct_req_if.sink                      i_req,
    rmct_rsp_if.source                    o_rsp,
    output logic                          o_ram_we,
    output logic [AW-1:0]                 o_ram_waddr,
    output logic [EW-1:0]                 o_ram_wdata,
    output logic [AW-1:0]                 o_ram_raddr_a,
    input  logic [EW-1:0]                 i_ram_rdata_a,
    output logic [AW-1:0]                 o_ram_raddr_b,
    input  logic [EW-1:0]                 i_ram_rdata_b,
    output rmct_pkg::t_status             o_status
);
    localparam int LW     = AW - 1;
    localparam int IW     = LW + 2;
    localparam int CW     = EW - VALUE_BITS;
    localparam int P      = 1 << LW;
    localparam int LenCap = (LEAF_COUNT < 2047) ? LEAF_COUNT : 2047;
    localparam int LNB    = rmct_pkg::LEN_BITS;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] val;
        logic [CW-1:0]                cnt;
    } t_node;

    localparam t_node IDENT = '{val: {1'b0, {(VALUE_BITS-1){1'b1}}}, cnt: '0};

    function automatic t_node node_merge(t_node a, t_node b);
        t_node m;
        if (a.val == b.val) begin
            m.val = a.val;
            m.cnt = CW'(a.cnt + b.cnt);
        end else if (a.val < b.val) begin
            m = a;
        end else begin
            m = b;
        end
        return m;
    endfunction

    rmct_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_clr_addr, n_clr_addr;
    logic [AW-1:0]    r_node, n_node;
    t_node            r_carry, n_carry;
    logic [IW-1:0]    r_l, n_l;
    logic [IW-1:0]    r_r, n_r;
    t_node            r_acc, n_acc;
    logic             r_pend_a, n_pend_a;
    logic             r_pend_b, n_pend_b;
    logic             r_empty, n_empty;
    logic             r_out_valid;
    t_node            r_out;
    logic             r_out_empty;

    t_node            rd_a, rd_b, up_merge, q_m1, q_m2, leaf_node;
    logic [LNB-1:0]   len, end_clip;
    logic             pos_ok, q_empty, out_free, load_out;
    logic [AW-1:0]    leaf_addr;

    assign rd_a = i_ram_rdata_a;
    assign rd_b = i_ram_rdata_b;

    assign len       = (i_active_length > LNB'(LenCap)) ? LNB'(LenCap) : i_active_length;
    assign pos_ok    = LNB'(i_req.position) < len;
    assign leaf_addr = {1'b1, LW'(i_req.position)};
    assign leaf_node = '{val: i_req.wr_value, cnt: CW'(1)};
    assign end_clip  = (i_req.range_end > len) ? len : i_req.range_end;
    assign q_empty   = i_req.range_start >= end_clip;

    assign up_merge = node_merge(r_carry, rd_a);
    assign q_m1     = r_pend_a ? node_merge(r_acc, rd_a) : r_acc;
    assign q_m2     = r_pend_b ? node_merge(q_m1, rd_b) : q_m1;
    assign out_free = !r_out_valid || o_rsp.ready;

    always_comb begin
        n_state       = r_state;
        n_clr_addr    = r_clr_addr;
        n_node        = r_node;
        n_carry       = r_carry;
        n_l           = r_l;
        n_r           = r_r;
        n_acc         = r_acc;
        n_pend_a      = 1'b0;
        n_pend_b      = 1'b0;
        n_empty       = r_empty;
        o_ram_we      = 1'b0;
        o_ram_waddr   = r_clr_addr;
        o_ram_wdata   = IDENT;
        o_ram_raddr_a = '0;
        o_ram_raddr_b = '0;
        load_out      = 1'b0;
        i_req.ready   = 1'b0;
        unique case (r_state)
            rmct_pkg::ST_CLEAR: begin
                o_ram_we   = 1'b1;
                n_clr_addr = r_clr_addr + AW'(1);
                if (&r_clr_addr) begin
                    n_state = rmct_pkg::ST_IDLE;
                end
            end
            rmct_pkg::ST_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    if (i_req.opcode == rmct_pkg::OP_WRITE) begin
                        // out-of-range writes are taken and dropped
                        if (pos_ok) begin
                            o_ram_we      = 1'b1;
                            o_ram_waddr   = leaf_addr;
                            o_ram_wdata   = leaf_node;
                            o_ram_raddr_a = leaf_addr ^ AW'(1);
                            n_node        = leaf_addr >> 1;
                            n_carry       = leaf_node;
                            n_state       = rmct_pkg::ST_WRITE;
                        end
                    end else begin
                        n_empty = q_empty;
                        n_acc   = IDENT;
                        n_l     = q_empty ? '0 : IW'(P) + IW'(i_req.range_start);
                        n_r     = q_empty ? '0 : IW'(P) + IW'(end_clip);
                        n_state = rmct_pkg::ST_QUERY;
                    end
                end
            end
            rmct_pkg::ST_WRITE: begin
                // sibling of a node on the path is never written by this walk
                o_ram_we      = 1'b1;
                o_ram_waddr   = r_node;
                o_ram_wdata   = up_merge;
                o_ram_raddr_a = r_node ^ AW'(1);
                n_carry       = up_merge;
                n_node        = r_node >> 1;
                if (r_node == AW'(1)) begin
                    n_state = rmct_pkg::ST_IDLE;
                end
            end
            rmct_pkg::ST_QUERY: begin
                n_acc = q_m2;
                if (r_l < r_r) begin
                    o_ram_raddr_a = AW'(r_l);
                    o_ram_raddr_b = AW'(r_r - IW'(1));
                    n_pend_a      = r_l[0];
                    n_pend_b      = r_r[0];
                    n_l           = (r_l + IW'(r_l[0])) >> 1;
                    n_r           = r_r >> 1;
                end else if (out_free) begin
                    load_out = 1'b1;
                    n_state  = rmct_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rmct_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rmct_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_pend_a    <= 1'b0;
            r_pend_b    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_pend_a   <= n_pend_a;
            r_pend_b   <= n_pend_b;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_node  <= n_node;
        r_carry <= n_carry;
        r_l     <= n_l;
        r_r     <= n_r;
        r_acc   <= n_acc;
        r_empty <= n_empty;
        if (load_out) begin
            r_out       <= n_acc;
            r_out_empty <= r_empty;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.min_value   = r_out.val;
    assign o_rsp.min_count   = rmct_pkg::COUNT_OUT_BITS'(r_out.cnt);
    assign o_rsp.range_empty = r_out_empty;

    assign o_status.clearing = (r_state == rmct_pkg::ST_CLEAR);
    assign o_status.querying = (r_state == rmct_pkg::ST_QUERY);
endmodule

// ===== rtl/core/range_min_with_count_tree.sv =====
// Range minimum with count over LEAF_COUNT signed elements, held as a binary
// tree in one memory (one write and two read ports, registered read). Each
// node stores the minimum of its span and how many elements equal it. A
// write item stores one element and refreshes its ancestors, one tree level
// per cycle, walking from the leaf to the root through the memory. A query
// item walks its two range bounds upward, reading up to two nodes per
// level on the two read ports, and yields one result. One item is worked at
// a time; the result register lets the next item in while a result waits.
// Writes at or beyond active_length are dropped, query ends are clipped to
// it. After reset a clearing pass sets all 2 * 2^ceil(log2(LEAF_COUNT))
// nodes to (largest value, count 0), one per cycle; no item is taken until
// it finishes.
module range_min_with_count_tree #(
    parameter int LEAF_COUNT = rmct_pkg::DEF_LEAF_COUNT,
    parameter int VALUE_BITS = rmct_pkg::DEF_VALUE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    rmct_req_if.sink                      i_req,
    rmct_rsp_if.source                    o_rsp,
    input  logic                          i_cfg_we,
    input  logic [rmct_pkg::LEN_BITS-1:0] i_cfg_wdata
);
    localparam int AW    = $clog2(LEAF_COUNT) + 1;
    localparam int EW    = VALUE_BITS + $clog2(LEAF_COUNT + 1);
    localparam int DEPTH = 1 << AW;

    logic [rmct_pkg::LEN_BITS-1:0] r_active_length;
    rmct_pkg::t_status             w_status;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr_a, ram_raddr_b;
    logic [EW-1:0] ram_wdata, ram_rdata_a, ram_rdata_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_length <= rmct_pkg::LEN_RESET;
        end else if (i_cfg_we) begin
            r_active_length <= i_cfg_wdata;
        end
    end

    rmct_ctrl #(
        .LEAF_COUNT (LEAF_COUNT),
        .VALUE_BITS (VALUE_BITS),
        .AW         (AW),
        .EW         (EW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_active_length (r_active_length),
        .i_req           (i_req),
        .o_rsp           (o_rsp),
        .o_ram_we        (ram_we),
        .o_ram_waddr     (ram_waddr),
        .o_ram_wdata     (ram_wdata),
        .o_ram_raddr_a   (ram_raddr_a),
        .i_ram_rdata_a   (ram_rdata_a),
        .o_ram_raddr_b   (ram_raddr_b),
        .i_ram_rdata_b   (ram_rdata_b),
        .o_status        (w_status)
    );

    rmct_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_node_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .o_rdata_a (ram_rdata_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_b (ram_rdata_b)
    );

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> w_status.clearing)
        else $error("clearing pass not started after reset");

    a_no_transfer_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.clearing |-> !i_req.ready)
        else $error("input ready during clearing pass");

    a_query_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && i_req.opcode == rmct_pkg::OP_QUERY)
            |=> !i_req.ready)
        else $error("input ready right after a query transfer");

    a_result_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(w_status.querying))
        else $error("result appeared without a query in progress");
endmodule
